// ===== rtl/core/kbw_pkg.sv =====
// ----------------------------------------------------------------------------
// kbw_pkg
// Shared types and constants of the Kaiser-Bessel window evaluator
// (alpha = 2.5 pi): Horner coefficients, reset scale and the stage bundle.
// ----------------------------------------------------------------------------
package kbw_pkg;

  // Number of Horner coefficients (degree 12 polynomial in arg)
  localparam int NUM_COEF = 13;

  // Pipeline depth from accept edge to result strobe:
  // input, scale multiply, square, arg, two per Horner step, output
  localparam int LATENCY = 4 + 2 * (NUM_COEF - 1) + 1;

  // Reset value of the scale register: 1.0 in Q8.24
  localparam logic [31:0] SCALE_RESET = 32'h0100_0000;

  // Window polynomial coefficients, unsigned Q0.32, rounded to nearest.
  // Index k multiplies arg^k.
  localparam logic [31:0] COEF_Q32 [NUM_COEF] = '{
    32'd11514021,
    32'd177560672,
    32'd684552183,
    32'd1172961673,
    32'd1130533954,
    32'd697370181,
    32'd298731241,
    32'd94016555,
    32'd22653960,
    32'd4312994,
    32'd665118,
    32'd84768,
    32'd9078
  };

  // Word carried between Horner stages
  typedef struct packed {
    logic        valid;   // stage holds a word
    logic        in_win;  // position strictly inside the window
    logic [32:0] arg;     // 1 - u^2, Q1.32 (2^32 means 1.0)
    logic [31:0] acc;     // Horner accumulator, Q0.32
  } stage_t;

endpackage

// ===== rtl/core/kbw_front.sv =====
// ----------------------------------------------------------------------------
// kbw_front
// Front end: magnitude of the position, scaling by 2/W, window test,
// square and arg = 1 - u^2. Four register stages, one word per cycle.
// ----------------------------------------------------------------------------
module kbw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic signed [31:0]  position_i,
  input  logic [31:0]         scale_i,
  output kbw_pkg::stage_t     out_o
);

  logic        v1_q, v2_q, v3_q, v4_q;
  logic [31:0] mag_d, mag_q;
  logic [63:0] m_d;
  logic        out2_q, out3_q, out4_q;
  logic [31:0] u2_q;
  logic [63:0] sq_full;
  logic [31:0] sq3_q;
  logic [32:0] arg_d, arg4_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage 1: magnitude; the most negative value wraps to 2^31 exactly
  assign mag_d = position_i[31] ? (~position_i + 32'd1) : position_i;

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  // Stage 2: m = |x| * scale, Q24.40; outside when m >= 1.0
  assign m_d = {32'd0, mag_q} * {32'd0, scale_i};

  always_ff @(posedge clk_i) begin
    out2_q <= |m_d[63:40];
    u2_q   <= m_d[39:8];
  end

  // Stage 3: u^2, Q0.32 truncated
  assign sq_full = {32'd0, u2_q} * {32'd0, u2_q};

  always_ff @(posedge clk_i) begin
    out3_q <= out2_q;
    sq3_q  <= sq_full[63:32];
  end

  // Stage 4: arg = 1 - u^2
  assign arg_d = 33'h1_0000_0000 - {1'b0, sq3_q};

  always_ff @(posedge clk_i) begin
    out4_q <= out3_q;
    arg4_q <= arg_d;
  end

  // Horner starts from the top coefficient
  assign out_o.valid  = v4_q;
  assign out_o.in_win = ~out4_q;
  assign out_o.arg    = arg4_q;
  assign out_o.acc    = kbw_pkg::COEF_Q32[kbw_pkg::NUM_COEF-1];

endmodule

// ===== rtl/core/kbw_step.sv =====
// ----------------------------------------------------------------------------
// kbw_step
// One Horner step: acc' = min((acc * arg) >> 32 + coef, 2^32 - 1).
// Multiply in the first stage, add and clamp in the second.
// ----------------------------------------------------------------------------
module kbw_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       coef_i,
  input  kbw_pkg::stage_t   in_i,
  output kbw_pkg::stage_t   out_o
);

  logic [63:0] prod;
  logic [31:0] hi_d, hi_q;
  logic        a_valid_q, a_in_win_q;
  logic [32:0] a_arg_q;
  logic [32:0] sum;
  logic [31:0] acc_d, acc_q;
  logic        b_valid_q, b_in_win_q;
  logic [32:0] b_arg_q;

  // Stage A: product high word; arg == 1.0 passes acc unchanged
  assign prod = {32'd0, in_i.acc} * {32'd0, in_i.arg[31:0]};
  assign hi_d = in_i.arg[32] ? in_i.acc : prod[63:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_i.valid;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_in_win_q <= in_i.in_win;
    a_arg_q    <= in_i.arg;
    hi_q       <= hi_d;
  end

  // Stage B: add coefficient, clamp to 32 bits
  assign sum   = {1'b0, hi_q} + {1'b0, coef_i};
  assign acc_d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  always_ff @(posedge clk_i) begin
    b_in_win_q <= a_in_win_q;
    b_arg_q    <= a_arg_q;
    acc_q      <= acc_d;
  end

  assign out_o.valid  = b_valid_q;
  assign out_o.in_win = b_in_win_q;
  assign out_o.arg    = b_arg_q;
  assign out_o.acc    = acc_q;

endmodule

// ===== rtl/core/kaiser_bessel_window_eval_unit.sv =====
// ----------------------------------------------------------------------------
// kaiser_bessel_window_eval_unit
// Kaiser-Bessel window (alpha = 2.5 pi) evaluated at one sample position.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive position_i (signed Q16.16) with start high; the word is
//   taken at any edge where busy is low. busy stays low, so one position
//   may be issued every cycle.
//   Config: cfg_data_i holds 2/W as unsigned Q8.24, written when
//   cfg_valid_i and cfg_ready_o are high. Write it only while no word is
//   in flight. Reset value is 1.0.
//   Output: done_o pulses for one cycle with window_value_o (unsigned
//   Q1.31) and inside_res_o. Outside the window the value is zero and
//   inside_res_o is low.
//   Depth: four front stages, then the twelve Horner steps, each a multiply
//   stage and an add/clamp stage, then one output stage.
//   Throughput: one word per cycle.
//   Reset clears all valid bits; words in flight are dropped. The receiver
//   takes every result in its cycle and cannot stall the pipeline.
// ----------------------------------------------------------------------------
module kaiser_bessel_window_eval_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] position_i,
  // result strobe
  output logic               done_o,
  output logic [31:0]        window_value_o,
  output logic               inside_res_o,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);

  logic [31:0]     scale_q;
  kbw_pkg::stage_t chain [kbw_pkg::NUM_COEF];
  logic            done_q;
  logic [31:0]     value_d, value_q;
  logic            in_win_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Scale register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= kbw_pkg::SCALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      scale_q <= cfg_data_i;
    end
  end

  // Front end
  kbw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start && !busy),
    .position_i (position_i),
    .scale_i    (scale_q),
    .out_o      (chain[0])
  );

  // Horner chain, top coefficient first
  for (genvar j = 0; j < kbw_pkg::NUM_COEF - 1; j++) begin : g_step
    kbw_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .coef_i (kbw_pkg::COEF_Q32[kbw_pkg::NUM_COEF-2-j]),
      .in_i   (chain[j]),
      .out_o  (chain[j+1])
    );
  end

  // Output register: Q0.32 to Q1.31, zero outside
  assign value_d = chain[kbw_pkg::NUM_COEF-1].in_win ?
                   {1'b0, chain[kbw_pkg::NUM_COEF-1].acc[31:1]} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain[kbw_pkg::NUM_COEF-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    in_win_q <= chain[kbw_pkg::NUM_COEF-1].in_win;
  end

  assign done_o         = done_q;
  assign window_value_o = value_q;
  assign inside_res_o   = in_win_q;

endmodule

// ===== rtl/core/kbw_checker.sv =====
// ----------------------------------------------------------------------------
// kbw_checker
// Port-level checks of the window evaluator: fixed latency, one result per
// accepted word, output range and zero value outside the window.
// ----------------------------------------------------------------------------
module kbw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] window_value_o,
  input logic        inside_res_o
);

  // Every accepted word yields a result after the fixed latency
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(kbw_pkg::LATENCY) done_o)
    else $error("accepted word produced no result");

  // No result without a word accepted that many cycles earlier
  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, kbw_pkg::LATENCY))
    else $error("result without matching accepted word");

  // Outside the window the value is zero
  a_outside_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !inside_res_o) |-> (window_value_o == 32'd0))
    else $error("nonzero value outside the window");

  // Q1.31 value never reaches 1.0
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !window_value_o[31])
    else $error("window value out of range");

endmodule

bind kaiser_bessel_window_eval_unit kbw_checker u_kbw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .window_value_o (window_value_o),
  .inside_res_o   (inside_res_o)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Kaiser-Bessel window evaluator. A queue-fed
// driver issues positions with random idle bursts. A clocked monitor
// predicts each window word in fixed point and compares results in order.
// The scale register is rewritten between phases while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam logic [31:0] SCALE_AT_RESET = 32'h0100_0000;
  localparam int          PHASE_ITEMS    = 150;
  localparam int          RANDOM_PHASES  = 8;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          CYCLE_LIMIT    = 300000;
  localparam int          REPORT_MAX     = 10;

  typedef struct {
    logic [31:0] value;
    logic        in_win;
  } window_word_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic [31:0] position_i   = '0;
  logic        done_o;
  logic [31:0] window_value_o;
  logic        inside_res_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i   = '0;

  logic [31:0]  pending_positions [$];
  window_word_t expected_windows  [$];
  logic [31:0]  scale_shadow = SCALE_AT_RESET;
  logic         quiet_mode   = 1'b0;
  int           idle_left    = 0;
  int           mismatches   = 0;
  int           cycle_count  = 0;

  kaiser_bessel_window_eval_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .position_i     (position_i),
    .done_o         (done_o),
    .window_value_o (window_value_o),
    .inside_res_o   (inside_res_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Horner coefficient k, rounded to nearest in unsigned Q0.32
  function automatic logic [31:0] window_coef(input int k);
    logic [63:0] num;
    logic [63:0] den;
    case (k)
      0:       begin num = 64'd2680816864; den = 64'd1000000000000;    end
      1:       begin num = 64'd413415655;  den = 64'd10000000000;      end
      2:       begin num = 64'd1593847253; den = 64'd10000000000;      end
      3:       begin num = 64'd2731014213; den = 64'd10000000000;      end
      4:       begin num = 64'd2632229482; den = 64'd10000000000;      end
      5:       begin num = 64'd1623691480; den = 64'd10000000000;      end
      6:       begin num = 64'd695537872;  den = 64'd10000000000;      end
      7:       begin num = 64'd218899351;  den = 64'd10000000000;      end
      8:       begin num = 64'd527453613;  den = 64'd100000000000;     end
      9:       begin num = 64'd1004197241; den = 64'd1000000000000;    end
      10:      begin num = 64'd1548598360; den = 64'd10000000000000;   end
      11:      begin num = 64'd1973663894; den = 64'd100000000000000;  end
      default: begin num = 64'd2113637354; den = 64'd1000000000000000; end
    endcase
    return 32'(((num << 32) + (den >> 1)) / den);
  endfunction

  // Window word for one position under a given scale
  function automatic window_word_t predict_window(input logic [31:0] pos,
                                                  input logic [31:0] scale);
    window_word_t res;
    logic [31:0]  mag;
    logic [63:0]  prod;
    logic [63:0]  u;
    logic [63:0]  sq;
    logic [63:0]  arg;
    logic [63:0]  acc;
    int           k;
    mag  = pos[31] ? (~pos + 32'd1) : pos;
    prod = {32'd0, mag} * {32'd0, scale};
    if (prod >= (64'd1 << 40)) begin
      res.value  = '0;
      res.in_win = 1'b0;
      return res;
    end
    u   = prod >> 8;
    sq  = (u * u) >> 32;
    arg = (64'd1 << 32) - sq;
    acc = {32'd0, window_coef(12)};
    for (k = 11; k >= 0; k--) begin
      acc = ((acc * arg) >> 32) + {32'd0, window_coef(k)};
      if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
    end
    res.value  = 32'(acc >> 1);
    res.in_win = 1'b1;
    return res;
  endfunction

  // Smallest magnitude that falls outside the window for this scale
  function automatic logic [63:0] boundary_mag(input logic [31:0] scale);
    return ((64'd1 << 40) + {32'd0, scale} - 64'd1) / {32'd0, scale};
  endfunction

  // Random position: any word, within twice the boundary magnitude, at the window edge, or a small magnitude
  function automatic logic [31:0] random_position(input logic [31:0] scale);
    logic [63:0] lim;
    logic [63:0] mag;
    logic        neg;
    int          mode;
    mode = $urandom_range(0, 3);
    neg  = $urandom_range(0, 1);
    if (mode == 0 || scale == 0) return $urandom;
    lim = boundary_mag(scale);
    if (lim > 64'h8000_0000) lim = 64'h8000_0000;
    case (mode)
      1:       mag = {$urandom, $urandom} % (2 * lim + 1);
      2:       mag = lim - 1 + $urandom_range(0, 1);
      default: mag = $urandom_range(0, 32'h0001_FFFF);
    endcase
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    if (!neg && mag == 64'h8000_0000) return 32'h7FFF_FFFF;
    return neg ? (~mag[31:0] + 32'd1) : mag[31:0];
  endfunction

  // Driver: hold each word until taken, insert idle bursts between words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      position_i <= '0;
      idle_left  <= 0;
    end else begin : drive
      logic        nxt_start;
      logic [31:0] nxt_pos;
      int          nxt_idle;
      nxt_start = start;
      nxt_pos   = position_i;
      nxt_idle  = idle_left;
      if (start && !busy) begin
        void'(pending_positions.pop_front());
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (nxt_idle > 0) begin
          nxt_idle--;
        end else if (pending_positions.size() > 0) begin
          if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            nxt_idle = $urandom_range(1, 13);
          end else begin
            nxt_start = 1'b1;
            nxt_pos   = pending_positions[0];
          end
        end
      end
      start      <= nxt_start;
      position_i <= nxt_pos;
      idle_left  <= nxt_idle;
    end
  end

  // Monitor: track scale writes, predict on accept, check on strobe
  always @(posedge clk_i) begin : observe
    window_word_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) scale_shadow = cfg_data_i;
      if (start && !busy)
        expected_windows.push_back(predict_window(position_i, scale_shadow));
      if (done_o) begin
        if (expected_windows.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected word: value %h inside %b", window_value_o,
                     inside_res_o);
        end else begin
          want = expected_windows.pop_front();
          if (window_value_o !== want.value || inside_res_o !== want.in_win) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch: value %h exp %h, inside %b exp %b",
                       window_value_o, want.value, inside_res_o, want.in_win);
          end
        end
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_positions.size() != 0 || expected_windows.size() != 0)
      @(negedge clk_i);
  endtask

  // Scale write, issued only with the pipe empty
  task automatic write_scale(input logic [31:0] value);
    wait_idle();
    if (!quiet_mode) repeat ($urandom_range(0, 13)) @(posedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [31:0] scale;
    int          p;
    int          i;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset scale 1.0: centre, extremes, both sides of the window edge
    pending_positions.push_back(32'h0000_0000);
    pending_positions.push_back(32'h0000_0001);
    pending_positions.push_back(32'hFFFF_FFFF);
    pending_positions.push_back(32'h7FFF_FFFF);
    pending_positions.push_back(32'h8000_0000);
    pending_positions.push_back(32'h0000_FFFF);
    pending_positions.push_back(32'h0001_0000);
    pending_positions.push_back(32'hFFFF_0001);
    pending_positions.push_back(32'hFFFF_0000);
    pending_positions.push_back(32'h0000_8000);
    pending_positions.push_back(32'hFFFF_8000);
    pending_positions.push_back(32'h0000_4000);
    wait_idle();

    // Zero scale: every position sits at the centre
    write_scale(32'h0000_0000);
    pending_positions.push_back(32'h7FFF_FFFF);
    pending_positions.push_back(32'h8000_0000);
    pending_positions.push_back(32'h0000_0000);
    pending_positions.push_back(32'h1234_5678);
    wait_idle();

    // Largest scale: edge between 256 and 257 LSBs
    write_scale(32'hFFFF_FFFF);
    pending_positions.push_back(32'h0000_0100);
    pending_positions.push_back(32'h0000_0101);
    pending_positions.push_back(32'hFFFF_FF00);
    pending_positions.push_back(32'hFFFF_FEFF);
    pending_positions.push_back(32'h8000_0000);
    wait_idle();

    // Random phases, one scale each; the last one runs without idling
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       scale = 32'h0100_0000;
        1:       scale = 32'h0000_0001;
        2:       scale = 32'h0040_0000;
        3:       scale = 32'h1000_0000;
        4:       scale = $urandom;
        5:       scale = $urandom_range(1, 32'h0000_FFFF);
        6:       scale = 32'hFFFF_FFFF;
        default: scale = 32'h0200_0000;
      endcase
      if (p == RANDOM_PHASES - 1) quiet_mode = 1'b1;
      write_scale(scale);
      for (i = 0; i < PHASE_ITEMS; i++)
        pending_positions.push_back(random_position(scale));
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && expected_windows.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
